/* rtl/core/mpbm_pkg.sv */
package mpbm_pkg;

  // Table and line geometry.
  localparam int NumPatterns   = 8;
  localparam int MaxPatternLen = 8;
  localparam int PositionBits  = 16;
  localparam int ResultLimit   = 64;

  // Derived widths.
  localparam int ByteW    = 8;
  localparam int PatIdxW  = $clog2(NumPatterns);
  localparam int PatCntW  = $clog2(NumPatterns + 1);
  localparam int OffW     = $clog2(MaxPatternLen);
  localparam int FillW    = $clog2(MaxPatternLen + 1);
  localparam int ResCntW  = $clog2(ResultLimit);
  localparam int CfgW     = 4;
  localparam int PosOutW  = 16;
  localparam int WinW     = MaxPatternLen * ByteW;
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;

  // Item modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SCAN = 1'b1;

  // Register index (word address bit of paddr).
  localparam logic REG_ACTIVE_PATTERNS = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_pat;   // store one pattern byte
    logic append;      // push one text byte into the window
    logic test;        // test current start against current pattern
    logic emit_marker; // send the end-of-line marker
    logic slide;       // drop the oldest window byte
    logic line_clear;  // return line state to its reset values
    logic pat_clr;
    logic pat_inc;
    logic idx_clr;
    logic idx_inc;
    logic cnt_clr;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_last_slot; // next text byte fills the window
    logic pat_done;       // every active pattern has been tested
    logic idx_done;       // every remaining start has been tested
    logic out_free;       // output register can take a new item
  } dp_status_t;

endpackage

/* rtl/core/mpbm_ctrl.sv */
module mpbm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 mode_i,
  input  logic                 last_i,
  output logic                 in_stall_o,
  input  mpbm_pkg::dp_status_t status_i,
  output mpbm_pkg::dp_cmd_t    cmd_o
);
  import mpbm_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  logic [1:0] state_q, state_d;

  // Items are taken only between line events.
  assign in_stall_o = (state_q != StIdle);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (mode_i == MODE_LOAD) begin
            cmd_o.write_pat = 1'b1;
          end else begin
            cmd_o.append  = 1'b1;
            cmd_o.pat_clr = 1'b1;
            cmd_o.idx_clr = 1'b1;
            cmd_o.cnt_clr = 1'b1;
            if (last_i) begin
              state_d = StFlush;
            end else if (status_i.fill_last_slot) begin
              state_d = StScan;
            end
          end
        end
      end
      StScan: begin
        // Test the oldest start against each active pattern, then slide.
        if (status_i.pat_done) begin
          cmd_o.slide = 1'b1;
          state_d     = StIdle;
        end else if (status_i.out_free) begin
          cmd_o.test    = 1'b1;
          cmd_o.pat_inc = 1'b1;
        end
      end
      StFlush: begin
        // Walk every remaining start, then close the line with a marker.
        if (status_i.idx_done) begin
          if (status_i.out_free) begin
            cmd_o.emit_marker = 1'b1;
            cmd_o.line_clear  = 1'b1;
            state_d           = StIdle;
          end
        end else if (status_i.pat_done) begin
          cmd_o.pat_clr = 1'b1;
          cmd_o.idx_inc = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.test    = 1'b1;
          cmd_o.pat_inc = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/mpbm_datapath.sv */
module mpbm_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mpbm_pkg::dp_cmd_t      cmd_i,
  output mpbm_pkg::dp_status_t   status_o,
  input  logic [3:0]             active_patterns_i,
  input  logic [2:0]             pattern_slot_i,
  input  logic [2:0]             char_offset_i,
  input  logic [7:0]             byte_value_i,
  input  logic                   last_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   is_match_o,
  output logic [15:0]            start_position_o,
  output logic [2:0]             matched_pattern_o,
  output logic                   position_saturated_o,
  output logic                   line_done_o
);
  import mpbm_pkg::*;

  // Pattern table: one row of bytes per pattern, filled byte by byte.
  logic [WinW-1:0]  pat_row_q [NumPatterns];
  logic [FillW-1:0] pat_len_q [NumPatterns];

  // Line state.
  logic [WinW-1:0]         win_q;
  logic [FillW-1:0]        fill_q;
  logic [PositionBits-1:0] oldest_q;
  logic                    sat_flag_q;

  // Sequencing counters.
  logic [PatCntW-1:0] pat_q;
  logic [FillW-1:0]   idx_q;
  logic [ResCntW-1:0] cnt_q;

  // Output register.
  logic               out_valid_q;
  logic               is_match_q;
  logic [PosOutW-1:0] pos_q;
  logic [PatIdxW-1:0] pat_out_q;
  logic               sat_out_q;
  logic               done_q;

  logic [PatCntW-1:0]    n_act;
  logic [WinW-1:0]       cur_row;
  logic [FillW-1:0]      cur_len;
  logic [WinW-1:0]       win_shift;
  logic [FillW-1:0]      avail;
  logic                  bytes_eq;
  logic                  hit;
  logic                  emit_match;
  logic                  out_free;
  logic [PositionBits:0] pos_sum;
  logic [PositionBits:0] end_sum;
  logic [PositionBits-1:0] pos_val;
  logic                  pos_sat;
  logic                  marker_sat;

  // Patterns above the table size act as the whole table.
  assign n_act = (active_patterns_i > CfgW'(NumPatterns)) ? PatCntW'(NumPatterns)
                                                           : PatCntW'(active_patterns_i);

  // Compare the current pattern with the window bytes from the current start.
  assign cur_row   = pat_row_q[pat_q[PatIdxW-1:0]];
  assign cur_len   = pat_len_q[pat_q[PatIdxW-1:0]];
  assign win_shift = win_q >> {idx_q, 3'b000};
  assign avail     = fill_q - idx_q;

  always_comb begin
    bytes_eq = 1'b1;
    for (int j = 0; j < MaxPatternLen; j++) begin
      if ((j < int'(cur_len)) && (win_shift[j*ByteW +: ByteW] != cur_row[j*ByteW +: ByteW])) begin
        bytes_eq = 1'b0;
      end
    end
  end

  assign hit        = (cur_len != '0) && (cur_len <= avail) && bytes_eq;
  assign emit_match = cmd_i.test && hit && (cnt_q < ResCntW'(ResultLimit - 1));

  // Start position with clamping at the top of the range.
  assign pos_sum = {1'b0, oldest_q} + (PositionBits+1)'(idx_q);
  assign pos_sat = pos_sum[PositionBits] | sat_flag_q;
  assign pos_val = pos_sum[PositionBits] ? '1 : pos_sum[PositionBits-1:0];

  // The marker reports whether the last byte of the line went past the range.
  assign end_sum    = {1'b0, oldest_q} + (PositionBits+1)'(fill_q) - (PositionBits+1)'(1);
  assign marker_sat = sat_flag_q | ((fill_q != '0) && end_sum[PositionBits]);

  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.fill_last_slot = (fill_q == FillW'(MaxPatternLen - 1));
  assign status_o.pat_done       = (pat_q == n_act);
  assign status_o.idx_done       = (idx_q == fill_q);
  assign status_o.out_free       = out_free;

  // Pattern bytes need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_pat) begin
      pat_row_q[pattern_slot_i][char_offset_i*ByteW +: ByteW] <= byte_value_i;
    end
  end

  // Pattern lengths; zero means the pattern never matches.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPatterns; i++) begin
        pat_len_q[i] <= '0;
      end
    end else if (cmd_i.write_pat && last_i) begin
      pat_len_q[pattern_slot_i] <= FillW'(char_offset_i) + FillW'(1);
    end
  end

  // Text window, fill level, oldest start and saturation flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      fill_q     <= '0;
      oldest_q   <= '0;
      sat_flag_q <= 1'b0;
    end else if (cmd_i.line_clear) begin
      win_q      <= '0;
      fill_q     <= '0;
      oldest_q   <= '0;
      sat_flag_q <= 1'b0;
    end else if (cmd_i.slide) begin
      win_q  <= win_q >> ByteW;
      fill_q <= fill_q - FillW'(1);
      if (oldest_q != '1) begin
        oldest_q <= oldest_q + PositionBits'(1);
      end else begin
        sat_flag_q <= 1'b1;
      end
    end else if (cmd_i.append) begin
      win_q[fill_q[OffW-1:0]*ByteW +: ByteW] <= byte_value_i;
      fill_q <= fill_q + FillW'(1);
    end
  end

  // Pattern, start and result counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.pat_clr) begin
        pat_q <= '0;
      end else if (cmd_i.pat_inc) begin
        pat_q <= pat_q + PatCntW'(1);
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + FillW'(1);
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (emit_match) begin
        cnt_q <= cnt_q + ResCntW'(1);
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_match || cmd_i.emit_marker) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (emit_match) begin
      is_match_q <= 1'b1;
      pos_q      <= PosOutW'(pos_val);
      pat_out_q  <= pat_q[PatIdxW-1:0];
      sat_out_q  <= pos_sat;
      done_q     <= 1'b0;
    end else if (cmd_i.emit_marker) begin
      is_match_q <= 1'b0;
      pos_q      <= '0;
      pat_out_q  <= '0;
      sat_out_q  <= marker_sat;
      done_q     <= 1'b1;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign is_match_o           = is_match_q;
  assign start_position_o     = pos_q;
  assign matched_pattern_o    = pat_out_q;
  assign position_saturated_o = sat_out_q;
  assign line_done_o          = done_q;

endmodule

/* rtl/core/multi_pattern_byte_matcher_core.sv */
// A scan item that fills the window tests the oldest start against each active pattern,
// one per cycle while the output is free, then slides. A line's last byte tests every
// buffered start so, then sends the marker. Other items take no stall. Throughput is
// set by the single pattern comparator, shared over patterns and starts.
// Reset clears pattern lengths, the window, the position state and the register.
module multi_pattern_byte_matcher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [2:0]  pattern_slot_i,
  input  logic [2:0]  char_offset_i,
  input  logic [7:0]  byte_value_i,
  input  logic        last_i,
  // Result items.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_match_o,
  output logic [15:0] start_position_o,
  output logic [2:0]  matched_pattern_o,
  output logic        position_saturated_o,
  output logic        line_done_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mpbm_pkg::*;

  logic [CfgW-1:0] active_q;
  dp_cmd_t         cmd;
  dp_status_t      status;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ACTIVE_PATTERNS)) begin
      active_q <= pwdata[CfgW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ACTIVE_PATTERNS) ? ApbDataW'(active_q) : '0;

  // Sequencer.
  mpbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .last_i     (last_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Pattern table, window and result register.
  mpbm_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .active_patterns_i    (active_q),
    .pattern_slot_i       (pattern_slot_i),
    .char_offset_i        (char_offset_i),
    .byte_value_i         (byte_value_i),
    .last_i               (last_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .is_match_o           (is_match_o),
    .start_position_o     (start_position_o),
    .matched_pattern_o    (matched_pattern_o),
    .position_saturated_o (position_saturated_o),
    .line_done_o          (line_done_o)
  );

endmodule
